@@ hw/rtl/grid_restrict_full_weighting_2d_top_defines.svh @@
// assertion macros for the grid restriction block
// no dependencies; included by files that carry concurrent checks
`ifndef GRID_RESTRICT_FULL_WEIGHTING_2D_TOP_DEFINES_SVH
`define GRID_RESTRICT_FULL_WEIGHTING_2D_TOP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define GRFW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid restriction check failed");
// next-cycle implication, disabled during reset
`define GRFW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid restriction check failed");
`else
`define GRFW_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GRFW_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/grfw2d_pkg.sv @@
// shared types and constants for the grid restriction block
// no dependencies
`timescale 1ns / 1ps

package grfw2d_pkg;

   // configuration register file
   localparam int CSR_DATA_BITS  = 10;
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COARSE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COARSE_HEIGHT = 2'd1;
   localparam logic [CSR_DATA_BITS-1:0]  CSR_SIZE_RESET    = 10'd512;

   // extra growth bits of the sums (weights 1,3,3,1 on both axes)
   localparam int VSUM_EXTRA = 3;
   localparam int HSUM_EXTRA = 6;

   // row slot codes (fine row mod 3)
   localparam logic [1:0] SLOT_0 = 2'd0;
   localparam logic [1:0] SLOT_1 = 2'd1;
   localparam logic [1:0] SLOT_2 = 2'd2;

   // per-sample control carried from accept into the memory stage
   typedef struct packed {
      logic row_emit;
      logic row_last;
      logic col_emit;
      logic col_last;
      logic x_ge2;
      logic x_ge3;
      logic y_ge2;
      logic y_ge3;
   } pos_flags_type;

endpackage

@@ hw/rtl/grid_restrict_full_weighting_2d_top.sv @@
// grid restriction, full weighting 4x4 cell-centered, top level
// depends on grfw2d_pkg and grid_restrict_full_weighting_2d_top_defines.svh
`timescale 1ns / 1ps
`include "grid_restrict_full_weighting_2d_top_defines.svh"

// Takes a fine grid of 2*coarse_width by 2*coarse_height signed samples in raster
// order, one per transfer, and returns each coarse cell as the 1,3,3,1 x 1,3,3,1
// weighted sum of its 4x4 fine neighborhood (edges clamped), scaled by 64. A cell
// leaves on the transfer that carries its last needed fine sample; the frame's
// final cell has frame_last set. Throughput is one sample per cycle outside input
// stalls: the three previous fine rows sit in one memory word per fine column, read
// once when a sample is taken and written back when that sample leaves the first
// stage, with a bypass for a repeated column. The input stalls only when a sample
// that closes a cell finds both the horizontal-sum stage and the output register
// full. A sample's result passes through the stage 1, stage 2 and output registers.
// The row memory needs no clear after reset. A size write takes effect at the next
// sample; when the current position lies outside the new grid the frame restarts
// at the origin. Zero is read as one and values above the maximum saturate.
module grid_restrict_full_weighting_2d_top #(
   parameter int MAX_COARSE_WIDTH  = 512,
   parameter int MAX_COARSE_HEIGHT = 512,
   parameter int SAMPLE_BITS       = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input sample channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_fine_sample,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS+5:0]         rsp_coarse_value,
   output logic                                  rsp_frame_last,
   // configuration write port
   input  logic                                  csr_write_enable,
   input  logic [grfw2d_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [grfw2d_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import grfw2d_pkg::*;

   localparam int XW    = $clog2(2 * MAX_COARSE_WIDTH);
   localparam int YW    = $clog2(2 * MAX_COARSE_HEIGHT);
   localparam int DEPTH = 2 * MAX_COARSE_WIDTH;
   localparam int SB    = SAMPLE_BITS;
   localparam int VW    = SAMPLE_BITS + VSUM_EXTRA;
   localparam int OW    = SAMPLE_BITS + HSUM_EXTRA;
   localparam int MW    = 3 * SAMPLE_BITS;

   // configuration registers
   logic [CSR_DATA_BITS-1:0] coarse_width_ff, coarse_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_width_ff  <= CSR_SIZE_RESET;
         coarse_height_ff <= CSR_SIZE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COARSE_WIDTH:  coarse_width_ff  <= csr_write_data;
            CSR_COARSE_HEIGHT: coarse_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // effective fine sizes, zero read as one, saturated at the maximum
   int          cw_int, ch_int;
   logic [XW-1:0] cw_eff;
   logic [YW-1:0] ch_eff;
   logic [XW:0]   fw;
   logic [YW:0]   fh;

   always_comb begin
      cw_int = int'(coarse_width_ff);
      ch_int = int'(coarse_height_ff);
      if (cw_int == 0) cw_eff = XW'(1);
      else if (cw_int > MAX_COARSE_WIDTH) cw_eff = XW'(MAX_COARSE_WIDTH);
      else cw_eff = XW'(cw_int);
      if (ch_int == 0) ch_eff = YW'(1);
      else if (ch_int > MAX_COARSE_HEIGHT) ch_eff = YW'(MAX_COARSE_HEIGHT);
      else ch_eff = YW'(ch_int);
      fw = {cw_eff, 1'b0};
      fh = {ch_eff, 1'b0};
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic accept, out_free, s2_free, s1_adv, s1_emit;
   pos_flags_type s1_flags_ff;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_emit  = s1_flags_ff.row_emit && s1_flags_ff.col_emit;
   assign s1_adv   = s1_valid_ff && (!s1_emit || s2_free);
   assign req_stall = s1_valid_ff && !s1_adv;

   // position counters, restart when outside the configured grid
   logic [XW-1:0] x_ff, x_in, xe;
   logic [YW-1:0] y_ff, y_in, ye;
   logic [1:0]    ymod_ff, ymod_in, ymod_e;
   logic [XW:0]   x_inc;
   logic [YW:0]   y_inc;
   logic          restart;
   pos_flags_type flags;

   always_comb begin
      restart = ({1'b0, x_ff} >= fw) || ({1'b0, y_ff} >= fh);
      xe      = restart ? '0 : x_ff;
      ye      = restart ? '0 : y_ff;
      ymod_e  = restart ? SLOT_0 : ymod_ff;

      flags.row_last = ({1'b0, ye} == fh - 1'b1);
      flags.col_last = ({1'b0, xe} == fw - 1'b1);
      flags.y_ge2    = ({1'b0, ye} >= (YW + 1)'(2));
      flags.y_ge3    = ({1'b0, ye} >= (YW + 1)'(3));
      flags.x_ge2    = ({1'b0, xe} >= (XW + 1)'(2));
      flags.x_ge3    = ({1'b0, xe} >= (XW + 1)'(3));
      flags.row_emit = (!ye[0] && flags.y_ge2) || flags.row_last;
      flags.col_emit = (!xe[0] && flags.x_ge2) || flags.col_last;

      x_inc   = {1'b0, xe} + 1'b1;
      y_inc   = {1'b0, ye} + 1'b1;
      x_in    = x_inc[XW-1:0];
      y_in    = ye;
      ymod_in = ymod_e;
      if (x_inc == fw) begin
         x_in = '0;
         if (y_inc == fh) begin
            y_in    = '0;
            ymod_in = SLOT_0;
         end else begin
            y_in    = y_inc[YW-1:0];
            ymod_in = (ymod_e == SLOT_2) ? SLOT_0 : ymod_e + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         ymod_ff <= SLOT_0;
      end else if (accept) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         ymod_ff <= ymod_in;
      end
   end

   // stage 1 registers: sample, column address, slot, flags
   logic signed [SB-1:0] s1_cur_ff;
   logic [XW-1:0]        s1_x_ff;
   logic [1:0]           s1_ymod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff   <= req_fine_sample;
         s1_x_ff     <= xe;
         s1_ymod_ff  <= ymod_e;
         s1_flags_ff <= flags;
      end
   end

   // row memory: one word per fine column, three row slots per word
   logic [MW-1:0] row_mem [DEPTH];
   logic [MW-1:0] mem_rd_ff, byp_word_ff, word_rd, word_wr;
   logic          byp_sel_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         row_mem[s1_x_ff] <= word_wr;
      end
      if (accept) begin
         mem_rd_ff   <= row_mem[xe];
         byp_word_ff <= word_wr;
      end
   end

   // bypass when the word being written back is the one being read
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_sel_ff <= 1'b0;
      end else if (accept) begin
         byp_sel_ff <= s1_adv && (s1_x_ff == xe);
      end
   end

   assign word_rd = byp_sel_ff ? byp_word_ff : mem_rd_ff;

   // slot lookup: previous rows y-1, y-2, y-3 and the write-back word
   logic signed [SB-1:0] prev1, prev2, prev3;
   logic signed [SB-1:0] lane0, lane1, lane2;

   assign lane0 = word_rd[0 * SB +: SB];
   assign lane1 = word_rd[1 * SB +: SB];
   assign lane2 = word_rd[2 * SB +: SB];

   always_comb begin
      word_wr = word_rd;
      unique case (s1_ymod_ff)
         SLOT_0: begin
            prev1 = lane2;
            prev2 = lane1;
            prev3 = lane0;
            word_wr[0 * SB +: SB] = s1_cur_ff;
         end
         SLOT_1: begin
            prev1 = lane0;
            prev2 = lane2;
            prev3 = lane1;
            word_wr[1 * SB +: SB] = s1_cur_ff;
         end
         SLOT_2: begin
            prev1 = lane1;
            prev2 = lane0;
            prev3 = lane2;
            word_wr[2 * SB +: SB] = s1_cur_ff;
         end
         default: begin
            prev1 = lane0;
            prev2 = lane0;
            prev3 = lane0;
         end
      endcase
   end

   // vertical 1,3,3,1 sum with clamped top and bottom rows
   logic signed [SB-1:0] ra, rb, rc, rd;
   logic signed [VW-1:0] va, vb, vc, vd, vsum;

   always_comb begin
      if (s1_flags_ff.row_last) begin
         ra = s1_flags_ff.y_ge2 ? prev2 : prev1;
         rb = prev1;
         rc = s1_cur_ff;
         rd = s1_cur_ff;
      end else begin
         ra = s1_flags_ff.y_ge3 ? prev3 : prev2;
         rb = prev2;
         rc = prev1;
         rd = s1_cur_ff;
      end
      va   = VW'(ra);
      vb   = VW'(rb);
      vc   = VW'(rc);
      vd   = VW'(rd);
      vsum = va + (vb <<< 1) + vb + (vc <<< 1) + vc + vd;
   end

   // window of the three previous column sums, newest first
   logic signed [VW-1:0] win_ff [3];
   logic signed [VW-1:0] ha, hb, hc;

   always_comb begin
      if (s1_flags_ff.col_last) begin
         ha = s1_flags_ff.x_ge2 ? win_ff[1] : win_ff[0];
         hb = win_ff[0];
         hc = vsum;
      end else begin
         ha = s1_flags_ff.x_ge3 ? win_ff[2] : win_ff[1];
         hb = win_ff[1];
         hc = win_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0] <= '0;
         win_ff[1] <= '0;
         win_ff[2] <= '0;
      end else if (s1_adv && s1_flags_ff.row_emit) begin
         win_ff[2] <= win_ff[1];
         win_ff[1] <= win_ff[0];
         win_ff[0] <= vsum;
      end
   end

   // stage 2: horizontal operands of an emitting cell
   logic signed [VW-1:0] s2_a_ff, s2_b_ff, s2_c_ff, s2_d_ff;
   logic                 s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv && s1_emit) begin
         s2_valid_ff <= 1'b1;
      end else if (out_free) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit) begin
         s2_a_ff    <= ha;
         s2_b_ff    <= hb;
         s2_c_ff    <= hc;
         s2_d_ff    <= vsum;
         s2_last_ff <= s1_flags_ff.row_last && s1_flags_ff.col_last;
      end
   end

   // horizontal 1,3,3,1 sum into the output register
   logic signed [OW-1:0] oa, ob, oc, od, osum;
   logic signed [OW-1:0] rsp_value_ff;
   logic                 rsp_last_ff;

   always_comb begin
      oa   = OW'(s2_a_ff);
      ob   = OW'(s2_b_ff);
      oc   = OW'(s2_c_ff);
      od   = OW'(s2_d_ff);
      osum = oa + (ob <<< 1) + ob + (oc <<< 1) + oc + od;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         rsp_value_ff <= osum;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coarse_value = rsp_value_ff;
   assign rsp_frame_last   = rsp_last_ff;

   // checks
   `GRFW_ASSERT_IMP(a_stall_needs_s1, clock, reset, req_stall, s1_valid_ff)
   `GRFW_ASSERT_IMP(a_slot_range, clock, reset, 1'b1, ymod_ff != 2'd3)
   `GRFW_ASSERT_IMP(a_row0_slot0, clock, reset, y_ff == '0, ymod_ff == SLOT_0)
   `GRFW_ASSERT_NXT(a_s2_held, clock, reset, s2_valid_ff && !out_free, s2_valid_ff)

endmodule

@@ dv/tb_grid_restrict_full_weighting_2d_top.sv @@
// testbench for the 4x4 full-weighting grid restriction block
// depends on grfw2d_pkg and grid_restrict_full_weighting_2d_top; predicts each coarse cell
// in step with accepted fine samples and checks every result transfer in order
`timescale 1ns / 1ps

module tb_grid_restrict_full_weighting_2d_top;
   import grfw2d_pkg::*;

   localparam int MAX_COARSE_WIDTH  = 512;
   localparam int MAX_COARSE_HEIGHT = 512;
   localparam int SAMPLE_BITS       = 32;
   localparam int OUT_BITS          = SAMPLE_BITS + 6;
   localparam int FINE_ROW_SPAN     = 2 * MAX_COARSE_WIDTH;
   localparam int MAX_WAIT          = 11;
   localparam int DRAIN_CYCLES      = 8;
   localparam int RANDOM_ITEMS      = 420;
   localparam int EXTREME_ITEMS     = 100;
   localparam int CYCLE_LIMIT       = 1000000;
   localparam int SHOWN_MISMATCHES  = 10;

   // register indexes past the two sizes, which the block ignores
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   typedef struct {
      logic signed [OUT_BITS-1:0] value;
      logic                       last;
   } coarse_cell_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [SAMPLE_BITS-1:0] req_fine_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [OUT_BITS-1:0] rsp_coarse_value;
   logic rsp_frame_last;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   // predictor state: sizes, three previous fine rows, vertical sums, position
   logic [CSR_DATA_BITS-1:0] grid_width_reg  = CSR_SIZE_RESET;
   logic [CSR_DATA_BITS-1:0] grid_height_reg = CSR_SIZE_RESET;
   longint fine_rows [0:2][0:FINE_ROW_SPAN-1];
   longint column_sums [0:2];
   int fine_x = 0;
   int fine_y = 0;

   coarse_cell_type coarse_expect_q[$];
   int  fail_count   = 0;
   int  items_sent   = 0;
   int  cycle_count  = 0;
   bit  sender_idle   = 1'b1;
   bit  receiver_idle = 1'b1;

   grid_restrict_full_weighting_2d_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_fine_sample  (req_fine_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coarse_value (rsp_coarse_value),
      .rsp_frame_last   (rsp_frame_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // zero reads as one, oversize saturates
   function automatic int coarse_size(input logic [CSR_DATA_BITS-1:0] raw, input int limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return int'(raw);
   endfunction

   // fine row r at column x, row y being the one now arriving
   function automatic longint fine_at(input int r, input int x, input int y, input longint cur);
      if (r == y) return cur;
      return fine_rows[r % 3][x];
   endfunction

   function automatic longint column_at(input int back, input longint vsum);
      if (back == 0) return vsum;
      return column_sums[back - 1];
   endfunction

   // advance the predictor by one fine sample, queue the coarse cell it completes
   task automatic restrict_sample(input logic signed [SAMPLE_BITS-1:0] sample);
      int fw, fh, x, y, ra, rb, rc, rd, ka, kb, kc, kd;
      bit row_last, row_emit, col_last, col_emit;
      longint cur, vsum, hsum;
      coarse_cell_type expected_cell;
      fw = 2 * coarse_size(grid_width_reg, MAX_COARSE_WIDTH);
      fh = 2 * coarse_size(grid_height_reg, MAX_COARSE_HEIGHT);
      x = fine_x;
      y = fine_y;
      cur = longint'(sample);
      // size shrank under the current position: frame restarts
      if (x >= fw || y >= fh) begin
         x = 0;
         y = 0;
      end
      row_last = (y == fh - 1);
      row_emit = ((y % 2) == 0 && y >= 2) || row_last;
      col_last = (x == fw - 1);
      col_emit = ((x % 2) == 0 && x >= 2) || col_last;
      if (row_emit) begin
         // vertical taps, bottom edge clamped
         if (row_last) begin
            ra = (y >= 2) ? y - 2 : y - 1;
            rb = y - 1;
            rc = y;
            rd = y;
         end else begin
            ra = (y >= 3) ? y - 3 : y - 2;
            rb = y - 2;
            rc = y - 1;
            rd = y;
         end
         vsum = fine_at(ra, x, y, cur) + 3 * fine_at(rb, x, y, cur)
              + 3 * fine_at(rc, x, y, cur) + fine_at(rd, x, y, cur);
         if (col_emit) begin
            // horizontal taps, right edge clamped
            if (col_last) begin
               ka = (x >= 2) ? 2 : 1;
               kb = 1;
               kc = 0;
               kd = 0;
            end else begin
               ka = (x >= 3) ? 3 : 2;
               kb = 2;
               kc = 1;
               kd = 0;
            end
            hsum = column_at(ka, vsum) + 3 * column_at(kb, vsum)
                 + 3 * column_at(kc, vsum) + column_at(kd, vsum);
            expected_cell.value = hsum[OUT_BITS-1:0];
            expected_cell.last  = row_last && col_last;
            coarse_expect_q.push_back(expected_cell);
         end
         column_sums[2] = column_sums[1];
         column_sums[1] = column_sums[0];
         column_sums[0] = vsum;
      end
      fine_rows[y % 3][x] = cur;
      x++;
      if (x >= fw) begin
         x = 0;
         y++;
         if (y >= fh) y = 0;
      end
      fine_x = x;
      fine_y = y;
   endtask

   // register write, with the enable dropped again before the task returns
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      if (index == CSR_COARSE_WIDTH) grid_width_reg = data;
      else if (index == CSR_COARSE_HEIGHT) grid_height_reg = data;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(input int cw, input int ch);
      write_csr(CSR_COARSE_WIDTH, cw[CSR_DATA_BITS-1:0]);
      write_csr(CSR_COARSE_HEIGHT, ch[CSR_DATA_BITS-1:0]);
   endtask

   // one fine sample transfer, with an optional gap before it
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample);
      int gap;
      gap = sender_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_fine_sample <= sample;
      do @(posedge clock); while (req_stall);
      restrict_sample(sample);
      items_sent++;
   endtask

   // extremes and small values weighted over plain random words
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return $signed($urandom_range(0, 31)) - 16;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_samples(input int count);
      repeat (count) send_sample(random_sample());
   endtask

   // let every expected cell come out, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (coarse_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // full-scale samples: checkerboard, most negative, most positive cells
   task automatic test_corner_samples();
      set_grid(2, 2);
      for (int i = 0; i < 16; i++)
         send_sample((((i & 3) ^ (i >> 2)) & 1) ? SAMPLE_MAX : SAMPLE_MIN);
      wait_idle();
      // zero sizes read as one
      set_grid(0, 0);
      repeat (4) send_sample(SAMPLE_MIN);
      wait_idle();
      set_grid(1, 1);
      repeat (4) send_sample(SAMPLE_MAX);
      wait_idle();
   endtask

   // writes to unused indexes leave the sizes alone
   task automatic test_spare_index();
      set_grid(2, 1);
      write_csr(CSR_SPARE_2, '1);
      write_csr(CSR_SPARE_3, '0);
      send_random_samples(8);
      wait_idle();
   endtask

   // height cut below the current row mid-frame restarts the frame
   task automatic test_restart_mid_frame();
      set_grid(4, 4);
      send_random_samples(30);
      wait_idle();
      write_csr(CSR_COARSE_HEIGHT, 10'd1);
      send_random_samples(16);
      wait_idle();
   endtask

   // widest and tallest grids with oversize values; each run is cut short by
   // shrinking the grid under the current position, then a full small frame
   task automatic test_size_extremes();
      set_grid(1023, 0);
      send_random_samples(EXTREME_ITEMS);
      wait_idle();
      write_csr(CSR_COARSE_WIDTH, 10'd2);
      send_random_samples(8);
      wait_idle();
      set_grid(1, 600);
      send_random_samples(EXTREME_ITEMS);
      wait_idle();
      write_csr(CSR_COARSE_HEIGHT, 10'd1);
      send_random_samples(4);
      wait_idle();
   endtask

   // whole frames of random small sizes with random idling modes
   task automatic test_random_frames();
      int first, cw, ch;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            cw = $urandom_range(9, 32);
            ch = $urandom_range(0, 2);
         end else begin
            cw = $urandom_range(0, 8);
            ch = $urandom_range(0, 5);
         end
         sender_idle   = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         set_grid(cw, ch);
         send_random_samples(4 * coarse_size(cw[CSR_DATA_BITS-1:0], MAX_COARSE_WIDTH)
                               * coarse_size(ch[CSR_DATA_BITS-1:0], MAX_COARSE_HEIGHT));
         wait_idle();
      end
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   // result side: random stall per cell, compare against the oldest prediction
   initial begin : result_checker
      int hold;
      coarse_cell_type expected_cell;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         hold = receiver_idle ? $urandom_range(0, MAX_WAIT) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !reset));
         if (coarse_expect_q.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
               $display("unexpected coarse cell: value %0d last %0b",
                        rsp_coarse_value, rsp_frame_last);
         end else begin
            expected_cell = coarse_expect_q.pop_front();
            if (rsp_coarse_value !== expected_cell.value ||
                rsp_frame_last !== expected_cell.last) begin
               fail_count++;
               if (fail_count <= SHOWN_MISMATCHES)
                  $display("coarse cell mismatch: expected value %0d last %0b, got %0d last %0b",
                           expected_cell.value, expected_cell.last,
                           rsp_coarse_value, rsp_frame_last);
            end
         end
      end
   end

   // test sequence
   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_fine_sample  <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_corner_samples();
      test_spare_index();
      test_restart_mid_frame();
      test_size_extremes();
      test_random_frames();
      wait_idle();
      fail_count += coarse_expect_q.size();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
